>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Signal must stay low whenever the guard holds.
`define ASSERT_NEVER(lbl, clk, rst_n, guard, sig, msg) \
    `ASSERT_CLKD(lbl, clk, rst_n, (guard) |-> !(sig), msg)

`endif

>>> rtl/core/cbsf_pkg.sv
// ----------------------------------------------------------------------------
// cbsf_pkg
// Types, codes and the stuffing function of the framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbsf_pkg;

    localparam logic [7:0] EOF_BYTE     = 8'hF0;
    localparam logic [7:0] ESC_BYTE     = 8'hF1;
    localparam logic [7:0] ESC_EOF_BYTE = 8'hF2;

    // output slots of one word, sent lowest first
    localparam int SLOTS = 5;
    localparam int SLOT_DATA0 = 0;
    localparam int SLOT_DATA1 = 1;
    localparam int SLOT_CHK0  = 2;
    localparam int SLOT_CHK1  = 3;
    localparam int SLOT_EOF   = 4;

    typedef logic [SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t                mask;
        logic [SLOTS-1:0][7:0]     bytes;
    } plan_t;

    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } stuffed_t;

    function automatic stuffed_t stuff(input logic [7:0] b);
        stuffed_t s;
        s.two    = 1'b0;
        s.first  = b;
        s.second = b;
        if (b == EOF_BYTE) begin
            s.two    = 1'b1;
            s.first  = ESC_BYTE;
            s.second = ESC_EOF_BYTE;
        end else if (b == ESC_BYTE) begin
            s.two    = 1'b1;
            s.first  = ESC_BYTE;
            s.second = ESC_BYTE;
        end
        return s;
    endfunction

endpackage

>>> rtl/core/cbsf_encoder.sv
// ----------------------------------------------------------------------------
// cbsf_encoder
// Running checksum and stuffing of one input word into an output slot plan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsf_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output cbsf_pkg::plan_t     plan
);

    logic [7:0]          checksum_reg;
    logic [7:0]          checksum_next;
    logic [7:0]          chk_sum;
    cbsf_pkg::stuffed_t  data_st;
    cbsf_pkg::stuffed_t  chk_st;

    assign chk_sum = checksum_reg - data_byte;
    assign data_st = cbsf_pkg::stuff(data_byte);
    assign chk_st  = cbsf_pkg::stuff(chk_sum);

    always_comb begin
        checksum_next = checksum_reg;
        if (load) begin
            checksum_next = last_byte ? 8'h00 : chk_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checksum_reg <= 8'h00;
        end else begin
            checksum_reg <= checksum_next;
        end
    end

    always_comb begin
        plan.bytes                        = '0;
        plan.mask                         = '0;
        plan.bytes[cbsf_pkg::SLOT_DATA0]  = data_st.first;
        plan.bytes[cbsf_pkg::SLOT_DATA1]  = data_st.second;
        plan.bytes[cbsf_pkg::SLOT_CHK0]   = chk_st.first;
        plan.bytes[cbsf_pkg::SLOT_CHK1]   = chk_st.second;
        plan.bytes[cbsf_pkg::SLOT_EOF]    = cbsf_pkg::EOF_BYTE;
        plan.mask[cbsf_pkg::SLOT_DATA0]   = 1'b1;
        plan.mask[cbsf_pkg::SLOT_DATA1]   = data_st.two;
        plan.mask[cbsf_pkg::SLOT_CHK0]    = last_byte;
        plan.mask[cbsf_pkg::SLOT_CHK1]    = last_byte & chk_st.two;
        plan.mask[cbsf_pkg::SLOT_EOF]     = last_byte;
    end

endmodule

>>> rtl/core/cbsf_serializer.sv
// ----------------------------------------------------------------------------
// cbsf_serializer
// Holds one slot plan and sends its live slots one word per cycle through
// the output register, while m_tready does not stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsf_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  cbsf_pkg::plan_t     plan,
    output logic                ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    cbsf_pkg::slot_mask_t              mask_reg;
    cbsf_pkg::slot_mask_t              mask_next;
    logic [cbsf_pkg::SLOTS-1:0][7:0]   bytes_reg;
    cbsf_pkg::slot_mask_t              sel;
    cbsf_pkg::slot_mask_t              rest;
    logic [7:0]                        sel_byte;
    logic                              out_adv;
    logic                              emit;
    logic                              done;
    logic                              valid_reg;
    logic                              valid_next;
    logic [7:0]                        data_reg;
    logic                              last_reg;
    logic                              eof_reg;

    assign sel  = mask_reg & (~mask_reg + cbsf_pkg::slot_mask_t'(1));
    assign rest = mask_reg & ~sel;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < cbsf_pkg::SLOTS; i++) begin
            sel_byte = sel_byte | (bytes_reg[i] & {8{sel[i]}});
        end
    end

    assign out_adv = !valid_reg || m_tready;
    assign emit    = out_adv && (mask_reg != '0);
    assign done    = emit && (rest == '0);
    assign ready   = (mask_reg == '0) || done;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = plan.mask;
        end else if (emit) begin
            mask_next = rest;
        end
        valid_next = out_adv ? emit : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= plan.bytes;
        end
        if (emit) begin
            data_reg <= sel_byte;
            last_reg <= (rest == '0);
            eof_reg  <= sel[cbsf_pkg::SLOT_EOF];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = eof_reg;

endmodule

>>> rtl/core/checksum_byte_stuffing_framer_top.sv
// ----------------------------------------------------------------------------
// checksum_byte_stuffing_framer_top
// Byte-stuffing framer with negated-sum checksum and end-of-frame marker.
//
//  channel | dir | tdata          | tlast     | tuser
//  s_      | in  | data_byte[7:0] | last_byte | -
//  m_      | out | out_byte[7:0]  | run_last  | frame_end
//
// One output word per cycle unless m_tready stalls; an input word yields 1 to
// 5 output words and occupies the single slot plan register until its final slot is sent.
// A new input word is taken in the cycle its predecessor sends its final slot.
// Output register stalls on m_tready; stall holds a plan with live slots left, and the checksum with it.
// Synchronous active-low reset clears checksum, plan and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module checksum_byte_stuffing_framer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser     // [0] frame_end
);

    cbsf_pkg::plan_t plan;
    logic            load;
    logic            ready;

    assign s_tready = ready;
    assign load     = s_tvalid && ready;

    cbsf_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .plan      (plan)
    );

    cbsf_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .plan      (plan),
        .ready     (ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `ASSERT_CLKD(a_eof_is_last, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast, "eof not last")
    `ASSERT_CLKD(a_eof_code, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == cbsf_pkg::EOF_BYTE), "bad eof code")
    `ASSERT_NEVER(a_no_raw_eof, aclk, aresetn, m_tvalid && (m_tdata == cbsf_pkg::EOF_BYTE), !m_tuser, "unstuffed eof")

endmodule
